@@ hdl/ctb_pkg.sv @@
// ----------------------------------------------------------------------------
// Combining tree barrier package
// Shared widths, the node step and result records, and the tree size helper.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int unsigned IdW      = 6;
  localparam int unsigned TcW      = 7;
  localparam int unsigned TopW     = 6;
  localparam int unsigned CntW     = 2;
  localparam int unsigned IdxW     = TcW + 1;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned ResetCount = 64;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    cnt_t wr_cnt;
    logic fill;
    logic rel;
    idx_t parent;
    idx_t base_n;
    idx_t span_n;
  } step_t;

  typedef struct packed {
    logic [TopW-1:0] top_node;
    logic            sense_after;
    logic            released;
  } result_t;

  function automatic idx_t pow2_ceil(logic [TcW-1:0] v);
    idx_t n;
    n = idx_t'(1);
    for (int i = 0; i < TcW; i++) begin
      if (n < {1'b0, v}) begin
        n = n << 1;
      end
    end
    return n;
  endfunction

endpackage

@@ hdl/ctb_node_unit.sv @@
// ----------------------------------------------------------------------------
// Combining tree barrier node unit
// Increments one node counter, checks it against the node quota and forms
// the parent node and its thread span for the next level.
// ----------------------------------------------------------------------------
module ctb_node_unit (
  input  ctb_pkg::idx_t           node_i,
  input  ctb_pkg::idx_t           base_i,
  input  ctb_pkg::idx_t           span_i,
  input  logic [ctb_pkg::TcW-1:0] live_i,
  input  ctb_pkg::cnt_t           cnt_i,
  input  logic                    cnt_vld_i,
  output ctb_pkg::step_t          step_o
);
  import ctb_pkg::*;

  idx_t          upper;
  idx_t          span_n;
  cnt_t          cnt_prev;
  cnt_t          quota;
  logic [CntW:0] inc;

  // A node on the path of a live thread always has its left half in use.
  always_comb begin
    upper    = base_i + (span_i >> 1);
    quota    = (upper < {1'b0, live_i}) ? CntW'(2) : CntW'(1);
    cnt_prev = cnt_vld_i ? cnt_i : '0;
    inc      = {1'b0, cnt_prev} + (CntW+1)'(1);
    span_n   = span_i << 1;

    step_o.wr_cnt = (&cnt_prev) ? cnt_prev : inc[CntW-1:0];
    step_o.fill   = (inc == {1'b0, quota});
    step_o.rel    = step_o.fill && (node_i[IdxW-1:1] == '0);
    step_o.parent = node_i >> 1;
    step_o.span_n = span_n;
    step_o.base_n = base_i & ~(span_n - idx_t'(1));
  end

endmodule

@@ hdl/ctb_cnt_mem.sv @@
// ----------------------------------------------------------------------------
// Combining tree barrier counter memory
// Node arrival counters with one registered read port, one write port and
// per-entry valid flags through which a single clear empties the whole tree.
// ----------------------------------------------------------------------------
module ctb_cnt_mem #(
  parameter int unsigned AddrW = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic           wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  ctb_pkg::cnt_t  wr_data_i,
  input  logic           clr_i,
  output ctb_pkg::cnt_t  rd_data_o,
  output logic           rd_vld_o
);
  import ctb_pkg::*;

  localparam int unsigned Depth = 1 << AddrW;

  cnt_t             mem_q [Depth];
  cnt_t             rd_data_q;
  logic [Depth-1:0] vld_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr_i];
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_vld_o  = rd_vld_q;

endmodule

@@ hdl/combining_tree_barrier.sv @@
// ----------------------------------------------------------------------------
// Combining tree barrier
// Sense-reversing barrier over a binary combining tree of arrival counters.
// ----------------------------------------------------------------------------
// Each word on the slave stream is one thread arrival. The arrival enters its
// leaf node and climbs one tree level per cycle through a shared node unit
// while each node fills its quota. When the root fills, all counters clear
// and the sense bit flips. One result word per arrival leaves on the master
// stream with the release flag, the new sense and the highest node touched.
// An arrival is accepted in the idle state, climbs the tree in the climb
// state, paced by the single node unit and counter memory port, and then
// hands its result to the output register from the done state. An
// arrival whose thread id is not below the count skips the climb. The
// block takes one arrival at a time; s_axis_tready is low while it works
// and while a thread count write is offered.
// The thread count register is written over the cfg channel while the block
// is idle; a write clears all counters and sets the sense to one.
// Reset gives a thread count of 64, cleared counters and sense one.
// When the receiver stalls, the result holds in the output register and the
// next arrival is still accepted; its result waits until the register frees.
// ----------------------------------------------------------------------------
module combining_tree_barrier #(
  parameter int unsigned MAX_THREADS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ctb_pkg::TcW-1:0]      cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // Fields from bit 0: thread_id[5:0], zero padding[7:6].
  input  logic [ctb_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // Fields from bit 0: released[0], sense_after[1], top_node[7:2].
  output logic [ctb_pkg::OutDataW-1:0] m_axis_tdata
);
  import ctb_pkg::*;

  localparam int unsigned MaxLog = $clog2(MAX_THREADS);
  localparam int unsigned NodeW  = (MaxLog < TcW) ? MaxLog : TcW;
  localparam int unsigned CountTop = (1 << TcW) - 1;
  localparam logic [TcW-1:0] LiveMax =
    TcW'((MAX_THREADS > CountTop) ? CountTop : MAX_THREADS);
  localparam logic [TcW-1:0] ResetLive =
    TcW'((MAX_THREADS < ResetCount) ? MAX_THREADS : ResetCount);

  typedef enum logic [1:0] {
    StIdle,
    StClimb,
    StDone
  } state_e;

  state_e           state_q;
  logic [TcW-1:0]   live_q;
  idx_t             size_q;
  logic             sense_q;
  idx_t             node_q;
  idx_t             base_q;
  idx_t             span_q;
  result_t          res_q;
  result_t          out_q;
  logic             out_vld_q;

  logic [IdW-1:0]   thread_id;
  logic [TcW-1:0]   live_d;
  logic             in_acc;
  logic             cfg_acc;
  logic             id_ok;
  idx_t             leaf;
  idx_t             rd_node;
  logic             mem_clr;
  logic             out_load;
  cnt_t             rd_cnt;
  logic             rd_vld;
  step_t            step;

  assign thread_id = s_axis_tdata[IdW-1:0];
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign cfg_acc   = cfg_valid_i && cfg_ready_o;
  assign id_ok     = {1'b0, thread_id} < {1'b0, live_q};
  assign leaf      = (idx_t'(thread_id) + size_q) >> 1;
  assign rd_node   = (state_q == StIdle) ? leaf : step.parent;
  assign mem_clr   = cfg_acc || ((state_q == StClimb) && step.rel);
  assign out_load  = (state_q == StDone) && (!out_vld_q || m_axis_tready);

  always_comb begin
    if (cfg_data_i == '0) begin
      live_d = TcW'(1);
    end else if (cfg_data_i > LiveMax) begin
      live_d = LiveMax;
    end else begin
      live_d = cfg_data_i;
    end
  end

  ctb_cnt_mem #(
    .AddrW(NodeW)
  ) u_cnt_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(rd_node[NodeW-1:0]),
    .wr_en_i  (state_q == StClimb),
    .wr_addr_i(node_q[NodeW-1:0]),
    .wr_data_i(step.wr_cnt),
    .clr_i    (mem_clr),
    .rd_data_o(rd_cnt),
    .rd_vld_o (rd_vld)
  );

  ctb_node_unit u_node_unit (
    .node_i   (node_q),
    .base_i   (base_q),
    .span_i   (span_q),
    .live_i   (live_q),
    .cnt_i    (rd_cnt),
    .cnt_vld_i(rd_vld),
    .step_o   (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      live_q    <= ResetLive;
      size_q    <= pow2_ceil(ResetLive);
      sense_q   <= 1'b1;
      node_q    <= '0;
      base_q    <= '0;
      span_q    <= '0;
      res_q     <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_q     <= res_q;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (cfg_acc) begin
            live_q  <= live_d;
            size_q  <= pow2_ceil(live_d);
            sense_q <= 1'b1;
          end
          if (in_acc) begin
            if (id_ok) begin
              node_q  <= leaf;
              base_q  <= idx_t'({thread_id[IdW-1:1], 1'b0});
              span_q  <= idx_t'(2);
              state_q <= StClimb;
            end else begin
              res_q.released    <= 1'b0;
              res_q.sense_after <= sense_q;
              res_q.top_node    <= '0;
              state_q           <= StDone;
            end
          end
        end
        StClimb: begin
          if (step.fill && !step.rel) begin
            node_q <= step.parent;
            base_q <= step.base_n;
            span_q <= step.span_n;
          end else begin
            res_q.released    <= step.rel;
            res_q.sense_after <= sense_q ^ step.rel;
            res_q.top_node    <= node_q[TopW-1:0];
            if (step.rel) begin
              sense_q <= ~sense_q;
            end
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_load) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == StIdle);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ hdl/ctb_checker.sv @@
// ----------------------------------------------------------------------------
// Combining tree barrier checker
// Port-level properties of the barrier, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ctb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // A stalled result word keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // An accepted arrival is worked on before another one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("arrival accepted while busy");

  // Only the root node, or the single node of a one-thread tree, releases.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[7:3] == 5'd0)
    else $error("release reported below the root");

endmodule

bind combining_tree_barrier ctb_checker u_ctb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
